FILE: rtl/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types for the sorting engine: channel payloads, the link between
// neighboring sort cells and the per-cycle cell control.
// ----------------------------------------------------------------------------
package qse_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      value_type value;
      logic      last_in;
   } req_type;

   typedef struct packed {
      value_type sorted_value;
      logic      last_out;
      logic      overflow;
   } rsp_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic      occ;      // cell holds a value
      logic      greater;  // cell is empty or holds a value above the incoming one
      value_type value;
   } cell_link_type;

   typedef struct packed {
      logic insert;  // place the incoming value into the sorted row
      logic shift;   // move the row one place toward the head
   } cell_ctrl_type;

endpackage

FILE: rtl/qse_cell.sv
// ----------------------------------------------------------------------------
// qse_cell
// One place of the sorted row. On insert it keeps its value, takes the
// incoming value, or takes its left neighbor's value; on shift it takes its
// right neighbor's value.
// ----------------------------------------------------------------------------
module qse_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  qse_pkg::cell_ctrl_type ctrl,
   input  qse_pkg::value_type    new_value,
   input  qse_pkg::cell_link_type left_link,
   input  qse_pkg::cell_link_type right_link,
   output qse_pkg::cell_link_type link
);
   import qse_pkg::*;

   logic      occ_ff;
   logic      occ_in;
   value_type value_ff;
   value_type value_in;
   logic      greater;

   // Empty cells act as plus infinity.
   assign greater = !occ_ff || (value_ff > new_value);

   always_comb begin
      occ_in   = occ_ff;
      value_in = value_ff;
      if (ctrl.shift) begin
         occ_in   = right_link.occ;
         value_in = right_link.value;
      end else if (ctrl.insert) begin
         if (left_link.greater) begin
            occ_in   = left_link.occ;
            value_in = left_link.value;
         end else if (greater) begin
            occ_in   = 1'b1;
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      value_ff <= value_in;
   end

   assign link.occ     = occ_ff;
   assign link.greater = greater;
   assign link.value   = value_ff;

endmodule

FILE: rtl/quicksort_engine.sv
// ----------------------------------------------------------------------------
// quicksort_engine
// Collects signed values into a row of sort cells kept in ascending order and
// streams them out smallest first once the beat flagged last arrives.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | beat carries
//   --------+--------------------------------+-------------------------------
//   request | req_valid req_stall req_data   | value, last_in
//   result  | rsp_valid rsp_stall rsp_data   | sorted_value, last_out, overflow
//
// Cycles: one per request beat while loading; the row of DEPTH cells places
// each value in order in the cycle it is taken (parallel compare, shift
// right). After the last beat the row drains one result per cycle from its
// head while rsp_stall is low. req_stall is high for the whole drain; a
// stalled result holds the row still. Reset empties the row and clears the
// count and overflow mark; beats past DEPTH are dropped and flag it.
// ----------------------------------------------------------------------------
module quicksort_engine #(
   parameter int unsigned DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qse_pkg::rsp_type rsp_data
);
   import qse_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type     state_ff;
   state_type     state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic          dropped_ff;
   logic          dropped_in;

   logic          req_take;
   logic          rsp_take;
   logic          full;
   cell_ctrl_type ctrl;

   cell_link_type links [DEPTH];
   cell_link_type left_links [DEPTH];
   cell_link_type right_links [DEPTH];

   // Handshake: take requests only while loading, offer results while draining.
   assign req_stall = (state_ff == ST_DRAIN);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign full      = (count_ff == CNT_W'(DEPTH));

   // Drop the beat once the row is full.
   assign ctrl.insert = req_take && !full;
   assign ctrl.shift  = rsp_take;

   // Row of cells; the head cell sees a left neighbor that never wins, the
   // tail cell sees an empty right neighbor.
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign left_links[gi] = '{occ: 1'b1, greater: 1'b0, value: '0};
         end else begin : g_left
            assign left_links[gi] = links[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign right_links[gi] = '{occ: 1'b0, greater: 1'b1, value: '0};
         end else begin : g_right
            assign right_links[gi] = links[gi+1];
         end

         qse_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_value  (req_data.value),
            .left_link  (left_links[gi]),
            .right_link (right_links[gi]),
            .link       (links[gi])
         );
      end
   endgenerate

   // Sequencer: count the stored values, switch to drain on last.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last_in) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_take) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // Result comes straight from the head cell; it holds while stalled.
   assign rsp_data.sorted_value = links[0].value;
   assign rsp_data.last_out     = (count_ff == CNT_W'(1));
   assign rsp_data.overflow     = dropped_ff;

   // A result on offer always has a filled head cell behind it.
   a_head_filled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (links[0].occ && count_ff != '0))
      else $error("result offered from an empty row");

   // The last beat of a set always starts a drain.
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.last_in) |=> rsp_valid)
      else $error("last request beat did not start the drain");

   // After the final result the row is empty and loading resumes.
   a_drain_ends_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_out) |=> (!rsp_valid && !links[0].occ))
      else $error("row not empty after the final result");

   // Overflow only once the row is full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (dropped_ff && !rsp_valid) |-> full)
      else $error("overflow flagged before the row filled");

endmodule

FILE: tb/tb_quicksort_engine.sv
// ----------------------------------------------------------------------------
// tb_quicksort_engine
// Loads signed sets into the sorting engine, some short, some full, some past
// the store depth, and checks every sorted beat, its last mark and the
// overflow mark against a quicksort of the same set kept in the bench.
// ----------------------------------------------------------------------------
module tb_quicksort_engine;
   import qse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ROW_DEPTH    = 16;
   localparam int          RANDOM_BEATS = 240;
   localparam int          IDLE_PCT     = 22;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          HOLD_AFTER   = 60;   // results seen before the long hold
   localparam int          SETTLE       = 40;   // quiet cycles after the last result
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRILL_N      = 23;

   localparam value_type MIN_V = 32'sh8000_0000;
   localparam value_type MAX_V = 32'sh7fff_ffff;
   localparam rsp_type   NO_WANT = '0;

   // How the values of one random set are drawn.
   typedef enum int {WIDE, NARROW, EXTREMES, RISING, FALLING} flavor_type;

   // One row of the directed table; want is used only where fixed is set.
   typedef struct packed {
      value_type value;
      logic      last_in;
      logic      fixed;
      rsp_type   want;
   } drill_row_type;

   // What the sender tells the monitor about each beat it offers.
   typedef struct packed {
      logic    fixed;
      rsp_type want;
   } beat_note_type;

   // Directed sets:
   //   lone minimum, lone maximum (sets of one, result typed in),
   //   a short set with zero, minus one and a duplicate pair,
   //   a full store plus one more beat that is dropped and carries last.
   localparam drill_row_type DRILLS [DRILL_N] = '{
      '{MIN_V,          1'b1, 1'b1, '{MIN_V, 1'b1, 1'b0}},
      '{MAX_V,          1'b1, 1'b1, '{MAX_V, 1'b1, 1'b0}},
      '{32'sd0,         1'b0, 1'b0, NO_WANT},
      '{-32'sd1,        1'b0, 1'b0, NO_WANT},
      '{32'sd5,         1'b0, 1'b0, NO_WANT},
      '{32'sd5,         1'b1, 1'b0, NO_WANT},
      '{MAX_V,          1'b0, 1'b0, NO_WANT},
      '{32'sd700,       1'b0, 1'b0, NO_WANT},
      '{32'sd600,       1'b0, 1'b0, NO_WANT},
      '{32'sd500,       1'b0, 1'b0, NO_WANT},
      '{32'sd400,       1'b0, 1'b0, NO_WANT},
      '{32'sd300,       1'b0, 1'b0, NO_WANT},
      '{32'sd200,       1'b0, 1'b0, NO_WANT},
      '{32'sd100,       1'b0, 1'b0, NO_WANT},
      '{32'sd0,         1'b0, 1'b0, NO_WANT},
      '{-32'sd1,        1'b0, 1'b0, NO_WANT},
      '{-32'sd100,      1'b0, 1'b0, NO_WANT},
      '{-32'sd200,      1'b0, 1'b0, NO_WANT},
      '{32'sh5555_5555, 1'b0, 1'b0, NO_WANT},
      '{32'shaaaa_aaaa, 1'b0, 1'b0, NO_WANT},
      '{32'sd100,       1'b0, 1'b0, NO_WANT},
      '{MIN_V,          1'b0, 1'b0, NO_WANT},
      '{32'sh1234_5678, 1'b1, 1'b0, NO_WANT}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Bench copy of the engine: the values of the set being loaded, how many
   // are held and whether any beat of this set was dropped.
   value_type   held_vals [ROW_DEPTH];
   int unsigned held_count = 0;
   bit          held_spill = 1'b0;
   int          pending_lo [$];
   int          pending_hi [$];

   rsp_type       sorted_q [$];   // sorted beats still owed by the engine
   beat_note_type note_q   [$];   // one note per offered request beat

   int errors       = 0;
   int results_seen = 0;
   int beats_sent   = 0;
   int cycle_count  = 0;
   bit steady       = 1'b0;  // no random idling on either side while set

   quicksort_engine #(.DEPTH(ROW_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop in case the engine hangs or a beat never shows up.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Quicksort of the held values: first entry of a range as pivot, two
   // scanning indices, and a stack of ranges no deeper than the store.
   // ---------------------------------------------------------------------
   function automatic void swap_held(int a, int b);
      value_type t;
      t = held_vals[a];
      held_vals[a] = held_vals[b];
      held_vals[b] = t;
   endfunction

   function automatic int split_range(int lo, int hi);
      value_type pivot;
      int i;
      int j;
      pivot = held_vals[lo];
      i = lo;
      j = hi;
      while (i < j) begin
         while (i <= hi - 1 && held_vals[i] <= pivot) i++;
         while (j >= lo + 1 && held_vals[j] > pivot) j--;
         if (i < j) swap_held(i, j);
      end
      swap_held(lo, j);
      return j;
   endfunction

   // Drop ranges of one value, and ranges that find the stack full.
   function automatic void stack_range(int lo, int hi);
      if (lo < hi && pending_lo.size() < ROW_DEPTH) begin
         pending_lo.push_back(lo);
         pending_hi.push_back(hi);
      end
   endfunction

   function automatic void sort_held();
      int lo;
      int hi;
      int p;
      pending_lo.delete();
      pending_hi.delete();
      stack_range(0, int'(held_count) - 1);
      while (pending_lo.size() > 0) begin
         lo = pending_lo.pop_back();
         hi = pending_hi.pop_back();
         p = split_range(lo, hi);
         // Push the larger side first so the smaller one is split next.
         if (p - lo > hi - p) begin
            stack_range(lo, p - 1);
            stack_range(p + 1, hi);
         end else begin
            stack_range(p + 1, hi);
            stack_range(lo, p - 1);
         end
      end
   endfunction

   // Take one accepted request beat; on the last beat of a set, queue the
   // sorted beats the engine owes (or the typed-in beat for fixed rows).
   function automatic void load_beat(req_type beat, beat_note_type note);
      rsp_type r;
      if (held_count < ROW_DEPTH) begin
         held_vals[held_count] = beat.value;
         held_count++;
      end else begin
         held_spill = 1'b1;
      end
      if (beat.last_in) begin
         sort_held();
         if (note.fixed) begin
            sorted_q.push_back(note.want);
         end else begin
            for (int k = 0; k < int'(held_count); k++) begin
               r.sorted_value = held_vals[k];
               r.last_out     = (k == int'(held_count) - 1);
               r.overflow     = held_spill;
               sorted_q.push_back(r);
            end
         end
         held_count = 0;
         held_spill = 1'b0;
      end
   endfunction

   function automatic void match_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge, in one process, so
   // a request and a result on the same edge are handled in a fixed order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) load_beat(req_data, note_q.pop_front());
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (sorted_q.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual %0d/%0b/%0b",
                        $time, rsp_data.sorted_value, rsp_data.last_out,
                        rsp_data.overflow);
               errors++;
            end else begin
               want = sorted_q.pop_front();
               match_field("sorted_value", want.sorted_value, rsp_data.sorted_value);
               match_field("last_out", want.last_out, rsp_data.last_out);
               match_field("overflow", want.overflow, rsp_data.overflow);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender: offer one beat at the falling edge, idle at random first, and
   // hold the payload until the engine takes it.
   // ---------------------------------------------------------------------
   task automatic offer_beat(input value_type value, input logic last_in,
                             input logic fixed, input rsp_type want);
      req_type       beat;
      beat_note_type note;
      beat.value   = value;
      beat.last_in = last_in;
      note.fixed   = fixed;
      note.want    = want;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      note_q.push_back(note);
      // Advance past stalled edges; the beat goes in on the first free one.
      do @(posedge clock); while (req_stall);
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic value_type draw_value(flavor_type flavor, int k, value_type base);
      value_type picks [6];
      picks = '{MIN_V, MAX_V, 32'sd0, -32'sd1, MIN_V + 1, MAX_V - 1};
      case (flavor)
         WIDE:     return value_type'($urandom);
         NARROW:   return value_type'($urandom_range(8)) - 32'sd4;
         EXTREMES: return picks[$urandom_range(5)];
         RISING:   return base + value_type'(k);
         default:  return base - value_type'(k);
      endcase
   endfunction

   // One well-formed set of n beats, the last one flagged.
   task automatic offer_set(int n);
      flavor_type flavor;
      value_type  base;
      flavor = flavor_type'($urandom_range(4));
      base   = value_type'($urandom);
      for (int k = 0; k < n; k++)
         offer_beat(draw_value(flavor, k, base), k == n - 1, 1'b0, NO_WANT);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: stall at random, never while steady is set, and once hold
   // off for a long stretch so the engine backs up into the request side.
   // ---------------------------------------------------------------------
   initial begin
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!held_once && results_seen >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main flow: reset, directed table, random sets, drain, verdict.
   // ---------------------------------------------------------------------
   initial begin
      int pick;
      int n;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DRILLS[i])
         offer_beat(DRILLS[i].value, DRILLS[i].last_in, DRILLS[i].fixed, DRILLS[i].want);

      // Mostly short sets, some exactly full, some past the store depth.
      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         steady = (beats_sent >= 110 && beats_sent < 170);
         pick = $urandom_range(99);
         if (pick < 10)      n = $urandom_range(22, ROW_DEPTH + 1);
         else if (pick < 22) n = ROW_DEPTH;
         else                n = $urandom_range(ROW_DEPTH - 1, 1);
         offer_set(n);
      end
      steady    = 1'b0;
      req_valid <= 1'b0;

      // Wait out every owed beat, then a quiet spell for strays.
      while (sorted_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/qse_pkg.sv
rtl/qse_cell.sv
rtl/quicksort_engine.sv
tb/tb_quicksort_engine.sv
